[rtl/core/xxh_pkg.sv]
`default_nettype none
package xxh_pkg;

    localparam logic [63:0] P64_1 = 64'd11400714785074694791;
    localparam logic [63:0] P64_2 = 64'd14029467366897019727;
    localparam logic [63:0] P64_3 = 64'd1609587929392839161;
    localparam logic [63:0] P64_4 = 64'd9650029242287828579;
    localparam logic [63:0] P64_5 = 64'd2870177450012600261;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH,
        OP_LINIT,
        OP_LR_M1,
        OP_LR_ADD,
        OP_LR_M2,
        OP_CLRF,
        OP_CONV,
        OP_SEEDH,
        OP_MG_M1,
        OP_MG_M2,
        OP_MG_M3,
        OP_MG_A,
        OP_ADDLEN,
        OP_F8_M1,
        OP_F8_M2,
        OP_F8_M3,
        OP_F8_A,
        OP_W4_M,
        OP_W4_M2,
        OP_W4_A,
        OP_B_M,
        OP_B_M2,
        OP_AV_M1,
        OP_AV_M2,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic last;
        logic push;
        logic fill_top;
        logic seen;
        logic idx_last;
        logic f8_more;
        logic tail_w4;
        logic byte_more;
        logic out_free;
    } sts_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage
`default_nettype wire

[rtl/core/xxhash64_stream_hash.sv]
// xxhash64_stream_hash: XXH64 of one message, bytes taken big-endian in 8-byte beats.
// Input channel s_axis_*: tdata carries data_word and byte_count, tlast marks the
// final beat of a message (0 to 8 valid bytes). A non-last beat always counts 8 bytes.
// Output channel m_axis_*: one beat per message with the 64-bit hash.
// Configuration: seed_we/seed_wdata load the seed; write it only while idle.
// Every 64x64 product is built from three 32x32 partial products on one shared
// multiplier; the sequencer drives all work.
// Work per input beat: a plain word is loaded and buffered; a word closing a 32-byte
// stripe adds four lane rounds and a buffer clear, and on the first stripe of a
// message it also seeds the lanes.
// The last beat adds the finish: a lane merge if a stripe was seen, then a round
// per buffered word, a round for a 4-byte piece, a round per tail byte and
// the final mix.
// The result sits in an output register; input is taken again while it waits.
// If the receiver stalls with a hash still pending, the next finish holds before
// writing its result until the pending beat is taken.
// Reset (aresetn low, synchronous) clears the message state and sets the seed
// to its default, 9650029242287828579.
`default_nettype none
module xxhash64_stream_hash
    import xxh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] byte_count, zero pad
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] hash_value
    input  wire logic        seed_we,
    input  wire logic [63:0] seed_wdata
);

    cmd_t cmd;
    sts_t sts;

    xxh_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    xxh_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .seed_we       (seed_we),
        .seed_wdata    (seed_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

[rtl/core/xxh_dpath.sv]
`default_nettype none
module xxh_dpath
    import xxh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        seed_we,
    input  wire logic [63:0] seed_wdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata
);

    logic [63:0] seed_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] buf_reg [4];
    logic [2:0]  fill_reg;
    logic [31:0] len_reg;
    logic        seen_reg;
    logic [63:0] h_reg;
    logic [63:0] t_reg;
    logic [63:0] word_reg;
    logic [2:0]  n_reg;
    logic        last_reg;
    logic        push_reg;
    logic [1:0]  idx_reg;
    logic [2:0]  bidx_reg;
    logic        out_valid_reg;
    logic [63:0] out_reg;

    // multiplier state
    logic [63:0] ma_reg;
    logic [63:0] mb_reg;
    logic [63:0] mp_reg;
    logic [1:0]  mcnt_reg;
    logic        mbusy_reg;

    logic        is_mul;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [31:0] pa;
    logic [31:0] pb;
    logic [63:0] prod;
    logic        mul_done;
    logic [63:0] mul_res;
    logic [3:0]  cnt_in;
    logic [3:0]  cnt_clamp;
    logic        push_in;
    logic [7:0]  byte_sel;

    assign cnt_in    = s_axis_tdata[67:64];
    assign cnt_clamp = (cnt_in > 4'd8) ? 4'd8 : cnt_in;
    assign push_in   = !s_axis_tlast || (cnt_clamp == 4'd8);
    assign byte_sel  = word_reg[6'd63 - {bidx_reg, 3'b000} -: 8];

    // Select multiplier operands for the current step
    always_comb begin
        is_mul = 1'b1;
        op_a   = h_reg;
        op_b   = P64_1;
        unique case (cmd.op)
            OP_LR_M1: begin op_a = buf_reg[idx_reg]; op_b = P64_2; end
            OP_LR_M2: begin op_a = t_reg; op_b = P64_1; end
            OP_MG_M1: begin op_a = lane_reg[idx_reg]; op_b = P64_2; end
            OP_MG_M2: begin op_a = rotl64(t_reg, 31); op_b = P64_1; end
            OP_MG_M3: begin op_a = h_reg ^ t_reg; op_b = P64_1; end
            OP_F8_M1: begin op_a = buf_reg[idx_reg]; op_b = P64_2; end
            OP_F8_M2: begin op_a = rotl64(t_reg, 31); op_b = P64_1; end
            OP_F8_M3: begin op_a = rotl64(h_reg ^ t_reg, 27); op_b = P64_1; end
            OP_W4_M:  begin op_a = {32'd0, word_reg[63:32]}; op_b = P64_1; end
            OP_W4_M2: begin op_a = rotl64(h_reg ^ t_reg, 23); op_b = P64_2; end
            OP_B_M:   begin op_a = {56'd0, byte_sel}; op_b = P64_5; end
            OP_B_M2:  begin op_a = rotl64(h_reg ^ t_reg, 11); op_b = P64_1; end
            OP_AV_M1: begin op_a = h_reg ^ (h_reg >> 33); op_b = P64_2; end
            OP_AV_M2: begin op_a = h_reg ^ (h_reg >> 29); op_b = P64_3; end
            default:  is_mul = 1'b0;
        endcase
    end

    // One 32x32 partial product per cycle, low 64 bits of the full product
    always_comb begin
        unique case (mcnt_reg)
            2'd0:    begin pa = ma_reg[31:0];  pb = mb_reg[31:0]; end
            2'd1:    begin pa = ma_reg[31:0];  pb = mb_reg[63:32]; end
            default: begin pa = ma_reg[63:32]; pb = mb_reg[31:0]; end
        endcase
    end
    assign prod     = {32'd0, pa} * {32'd0, pb};
    assign mul_done = mbusy_reg && (mcnt_reg == 2'd2);
    assign mul_res  = mp_reg + {prod[31:0], 32'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= 2'd0;
        end else if (is_mul && !mbusy_reg) begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= 2'd0;
        end else if (mbusy_reg) begin
            if (mcnt_reg == 2'd2) begin
                mbusy_reg <= 1'b0;
            end
            mcnt_reg <= mcnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_mul && !mbusy_reg) begin
            ma_reg <= op_a;
            mb_reg <= op_b;
        end
        if (mbusy_reg && mcnt_reg == 2'd0) begin
            mp_reg <= prod;
        end else if (mbusy_reg && mcnt_reg == 2'd1) begin
            mp_reg <= mul_res;
        end
    end

    // Seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= P64_4;
        end else if (seed_we) begin
            seed_reg <= seed_wdata;
        end
    end

    // Message control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= 3'd0;
            len_reg       <= 32'd0;
            seen_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            bidx_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            push_reg      <= 1'b0;
            n_reg         <= 3'd0;
        end else begin
            // Raise the result beat on the write, drop it once taken
            if (cmd.op == OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD: begin
                    last_reg <= s_axis_tlast;
                    push_reg <= push_in;
                    n_reg    <= push_in ? 3'd0 : cnt_clamp[2:0];
                    len_reg  <= len_reg + (s_axis_tlast ? {28'd0, cnt_clamp} : 32'd8);
                end
                OP_PUSH: begin
                    fill_reg <= fill_reg + 3'd1;
                    idx_reg  <= 2'd0;
                end
                OP_LINIT:  seen_reg <= 1'b1;
                OP_LR_M2:  if (mul_done) idx_reg <= idx_reg + 2'd1;
                OP_CLRF: begin
                    fill_reg <= 3'd0;
                    idx_reg  <= 2'd0;
                end
                OP_CONV:   idx_reg <= 2'd0;
                OP_SEEDH:  idx_reg <= 2'd0;
                OP_MG_A:   idx_reg <= idx_reg + 2'd1;
                OP_ADDLEN: begin
                    idx_reg  <= 2'd0;
                    bidx_reg <= 3'd0;
                end
                OP_F8_A:   idx_reg <= idx_reg + 2'd1;
                OP_W4_A:   bidx_reg <= 3'd4;
                OP_B_M2:   if (mul_done) bidx_reg <= bidx_reg + 3'd1;
                OP_OUT: begin
                    fill_reg      <= 3'd0;
                    len_reg       <= 32'd0;
                    seen_reg      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD:   word_reg <= s_axis_tdata[63:0];
            OP_PUSH:   buf_reg[fill_reg[1:0]] <= word_reg;
            OP_LINIT: begin
                lane_reg[0] <= seed_reg + P64_1 + P64_2;
                lane_reg[1] <= seed_reg + P64_2;
                lane_reg[2] <= seed_reg;
                lane_reg[3] <= seed_reg - P64_1;
            end
            OP_LR_M1:  if (mul_done) t_reg <= mul_res;
            OP_LR_ADD: t_reg <= rotl64(lane_reg[idx_reg] + t_reg, 31);
            OP_LR_M2:  if (mul_done) lane_reg[idx_reg] <= mul_res;
            OP_CONV: begin
                h_reg <= rotl64(lane_reg[0], 1) + rotl64(lane_reg[1], 7)
                       + rotl64(lane_reg[2], 12) + rotl64(lane_reg[3], 18);
            end
            OP_SEEDH:  h_reg <= seed_reg + P64_5;
            OP_MG_M1, OP_MG_M2, OP_F8_M1, OP_F8_M2, OP_W4_M, OP_B_M: begin
                if (mul_done) t_reg <= mul_res;
            end
            OP_MG_M3, OP_F8_M3, OP_W4_M2, OP_B_M2, OP_AV_M1, OP_AV_M2: begin
                if (mul_done) h_reg <= mul_res;
            end
            OP_MG_A:   h_reg <= h_reg + P64_4;
            OP_F8_A:   h_reg <= h_reg + P64_4;
            OP_W4_A:   h_reg <= h_reg + P64_3;
            OP_ADDLEN: h_reg <= h_reg + {32'd0, len_reg};
            OP_OUT:    out_reg <= h_reg ^ (h_reg >> 32);
            default: ;
        endcase
    end

    // Status toward the controller
    always_comb begin
        sts.mul_done  = mul_done;
        sts.last      = last_reg;
        sts.push      = push_reg;
        sts.fill_top  = (fill_reg == 3'd3);
        sts.seen      = seen_reg;
        sts.idx_last  = (idx_reg == 2'd3);
        sts.f8_more   = ({1'b0, idx_reg} < fill_reg);
        sts.tail_w4   = (n_reg >= 3'd4);
        sts.byte_more = (bidx_reg < n_reg);
        sts.out_free  = !out_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule
`default_nettype wire

[rtl/core/xxh_ctrl.sv]
`default_nettype none
module xxh_ctrl
    import xxh_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [29:0] {
        S_IDLE   = 30'h0000_0001,
        S_DEC    = 30'h0000_0002,
        S_PUSH   = 30'h0000_0004,
        S_LINIT  = 30'h0000_0008,
        S_LR_M1  = 30'h0000_0010,
        S_LR_ADD = 30'h0000_0020,
        S_LR_M2  = 30'h0000_0040,
        S_CLRF   = 30'h0000_0080,
        S_FIN    = 30'h0000_0100,
        S_CONV   = 30'h0000_0200,
        S_SEEDH  = 30'h0000_0400,
        S_MG_M1  = 30'h0000_0800,
        S_MG_M2  = 30'h0000_1000,
        S_MG_M3  = 30'h0000_2000,
        S_MG_A   = 30'h0000_4000,
        S_ADDLEN = 30'h0000_8000,
        S_F8_CHK = 30'h0001_0000,
        S_F8_M1  = 30'h0002_0000,
        S_F8_M2  = 30'h0004_0000,
        S_F8_M3  = 30'h0008_0000,
        S_F8_A   = 30'h0010_0000,
        S_W4_M   = 30'h0020_0000,
        S_W4_M2  = 30'h0040_0000,
        S_W4_A   = 30'h0080_0000,
        S_B_CHK  = 30'h0100_0000,
        S_B_M    = 30'h0200_0000,
        S_B_M2   = 30'h0400_0000,
        S_AV_M1  = 30'h0800_0000,
        S_AV_M2  = 30'h1000_0000,
        S_OUT    = 30'h2000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence the steps of one beat
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:    state_next = sts.push ? S_PUSH : S_FIN;
            S_PUSH: begin
                cmd.op = OP_PUSH;
                if (sts.fill_top) begin
                    state_next = sts.seen ? S_LR_M1 : S_LINIT;
                end else begin
                    state_next = sts.last ? S_FIN : S_IDLE;
                end
            end
            S_LINIT: begin
                cmd.op     = OP_LINIT;
                state_next = S_LR_M1;
            end
            S_LR_M1: begin
                cmd.op = OP_LR_M1;
                if (sts.mul_done) state_next = S_LR_ADD;
            end
            S_LR_ADD: begin
                cmd.op     = OP_LR_ADD;
                state_next = S_LR_M2;
            end
            S_LR_M2: begin
                cmd.op = OP_LR_M2;
                if (sts.mul_done) state_next = sts.idx_last ? S_CLRF : S_LR_M1;
            end
            S_CLRF: begin
                cmd.op     = OP_CLRF;
                state_next = sts.last ? S_FIN : S_IDLE;
            end
            S_FIN:    state_next = sts.seen ? S_CONV : S_SEEDH;
            S_CONV: begin
                cmd.op     = OP_CONV;
                state_next = S_MG_M1;
            end
            S_SEEDH: begin
                cmd.op     = OP_SEEDH;
                state_next = S_ADDLEN;
            end
            S_MG_M1: begin
                cmd.op = OP_MG_M1;
                if (sts.mul_done) state_next = S_MG_M2;
            end
            S_MG_M2: begin
                cmd.op = OP_MG_M2;
                if (sts.mul_done) state_next = S_MG_M3;
            end
            S_MG_M3: begin
                cmd.op = OP_MG_M3;
                if (sts.mul_done) state_next = S_MG_A;
            end
            S_MG_A: begin
                cmd.op     = OP_MG_A;
                state_next = sts.idx_last ? S_ADDLEN : S_MG_M1;
            end
            S_ADDLEN: begin
                cmd.op     = OP_ADDLEN;
                state_next = S_F8_CHK;
            end
            S_F8_CHK: begin
                if (sts.f8_more) begin
                    state_next = S_F8_M1;
                end else begin
                    state_next = sts.tail_w4 ? S_W4_M : S_B_CHK;
                end
            end
            S_F8_M1: begin
                cmd.op = OP_F8_M1;
                if (sts.mul_done) state_next = S_F8_M2;
            end
            S_F8_M2: begin
                cmd.op = OP_F8_M2;
                if (sts.mul_done) state_next = S_F8_M3;
            end
            S_F8_M3: begin
                cmd.op = OP_F8_M3;
                if (sts.mul_done) state_next = S_F8_A;
            end
            S_F8_A: begin
                cmd.op     = OP_F8_A;
                state_next = S_F8_CHK;
            end
            S_W4_M: begin
                cmd.op = OP_W4_M;
                if (sts.mul_done) state_next = S_W4_M2;
            end
            S_W4_M2: begin
                cmd.op = OP_W4_M2;
                if (sts.mul_done) state_next = S_W4_A;
            end
            S_W4_A: begin
                cmd.op     = OP_W4_A;
                state_next = S_B_CHK;
            end
            S_B_CHK:  state_next = sts.byte_more ? S_B_M : S_AV_M1;
            S_B_M: begin
                cmd.op = OP_B_M;
                if (sts.mul_done) state_next = S_B_M2;
            end
            S_B_M2: begin
                cmd.op = OP_B_M2;
                if (sts.mul_done) state_next = S_B_CHK;
            end
            S_AV_M1: begin
                cmd.op = OP_AV_M1;
                if (sts.mul_done) state_next = S_AV_M2;
            end
            S_AV_M2: begin
                cmd.op = OP_AV_M2;
                if (sts.mul_done) state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
    import xxh_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  RANDOM_BEATS   = 1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        seed_we = 1'b0;
    logic [63:0] seed_wdata = '0;

    int          idle_cycles = 0;
    bit          rx_hold = 1'b0;
    bit          timed_out = 1'b0;
    int          beats_sent = 0;
    int          hashes_checked = 0;

    always #10 aclk = ~aclk;

    xxhash64_stream_hash DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .seed_we       (seed_we),
        .seed_wdata    (seed_wdata)
    );

    // Software XXH64 (big-endian variant) and the queue of hashes it predicts
    class xxh_scoreboard;
        logic [63:0] seed_r;
        logic [63:0] lanes [4];
        logic [63:0] stripe [4];
        int unsigned words_held;
        logic [31:0] msg_len;
        bit          lanes_live;
        logic [63:0] pending_hash [$];
        int          mismatches;

        function new();
            seed_r = P64_4;
            words_held = 0;
            msg_len = '0;
            lanes_live = 1'b0;
            mismatches = 0;
            foreach (lanes[i]) begin
                lanes[i] = '0;
                stripe[i] = '0;
            end
        endfunction

        function logic [63:0] rot(logic [63:0] x, int unsigned r);
            return (x << r) | (x >> (64 - r));
        endfunction

        function logic [63:0] lane_mix(logic [63:0] acc, logic [63:0] w);
            acc = acc + w * P64_2;
            return rot(acc, 31) * P64_1;
        endfunction

        function void add_word(logic [63:0] w);
            stripe[words_held] = w;
            words_held++;
            if (words_held == 4) begin
                if (!lanes_live) begin
                    lanes[0] = seed_r + P64_1 + P64_2;
                    lanes[1] = seed_r + P64_2;
                    lanes[2] = seed_r;
                    lanes[3] = seed_r - P64_1;
                    lanes_live = 1'b1;
                end
                for (int i = 0; i < 4; i++) lanes[i] = lane_mix(lanes[i], stripe[i]);
                words_held = 0;
            end
        endfunction

        // Note one accepted input beat; a last beat queues the finished hash
        function void note_beat(logic [63:0] w, logic [3:0] cnt, logic is_last);
            int unsigned n;
            logic [63:0] h;
            int unsigned k;
            n = (cnt > 8) ? 8 : cnt;
            if (!is_last) begin
                msg_len += 32'd8;
                add_word(w);
                return;
            end
            msg_len += n;
            if (n == 8) begin
                add_word(w);
                n = 0;
            end
            if (lanes_live) begin
                h = rot(lanes[0], 1) + rot(lanes[1], 7) + rot(lanes[2], 12)
                    + rot(lanes[3], 18);
                for (int i = 0; i < 4; i++) h = ((h ^ lane_mix('0, lanes[i])) * P64_1) + P64_4;
            end else begin
                h = seed_r + P64_5;
            end
            h += {32'd0, msg_len};
            for (int i = 0; i < words_held; i++)
                h = rot(h ^ lane_mix('0, stripe[i]), 27) * P64_1 + P64_4;
            k = 0;
            if (n >= 4) begin
                h ^= {32'd0, w[63:32]} * P64_1;
                h = rot(h, 23) * P64_2 + P64_3;
                k = 4;
            end
            for (; k < n; k++) begin
                h ^= {56'd0, w[63-8*k -: 8]} * P64_5;
                h = rot(h, 11) * P64_1;
            end
            h ^= h >> 33;
            h *= P64_2;
            h ^= h >> 29;
            h *= P64_3;
            h ^= h >> 32;
            pending_hash.push_back(h);
            words_held = 0;
            msg_len = '0;
            lanes_live = 1'b0;
        endfunction

        function void check_hash(logic [63:0] got);
            logic [63:0] want;
            if (pending_hash.size() == 0) begin
                $error("unexpected hash beat: hash_value actual %h", got);
                mismatches++;
                return;
            end
            want = pending_hash.pop_front();
            if (got !== want) begin
                $error("hash_value mismatch: expected %h actual %h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    xxh_scoreboard sb = new();

    // Monitor both channels and count idle cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_beat(s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tlast);
                beats_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_hash(m_axis_tdata);
                hashes_checked++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Receiver: random stalls, or a long hold-off when asked
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                rx_hold = 1'b0;
            end
            g = pick_gap();
            if ($urandom_range(0, 3) == 0) g = 0;
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    bit bursty = 1'b0;

    task automatic send_beat(logic [63:0] w, logic [3:0] cnt, logic is_last);
        int g;
        g = bursty ? 0 : pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, cnt, w};
        s_axis_tlast  <= is_last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_hash.size() != 0) @(posedge aclk);
        // extra margin; every message sent has already given its hash
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_seed(logic [63:0] v);
        seed_we    <= 1'b1;
        seed_wdata <= v;
        @(posedge aclk);
        seed_we    <= 1'b0;
        sb.seed_r = v;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random message: the given number of full 8-byte beats plus a last beat with a random count
    task automatic send_message(int unsigned words);
        for (int unsigned i = 0; i < words; i++)
            send_beat(rand64(), ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'd8, 1'b0);
        send_beat(rand64(), 4'($urandom_range(0, 15)), 1'b1);
    endtask

    initial begin
        int unsigned words;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, each tail size, extremes, stripe boundaries
        send_beat('0, 4'd0, 1'b1);
        for (int n = 1; n <= 8; n++) send_beat(64'h0123_4567_89AB_CDEF, 4'(n), 1'b1);
        send_beat('1, 4'd15, 1'b1);
        send_beat('1, 4'd3, 1'b0);
        send_beat('0, 4'd0, 1'b1);
        for (int i = 0; i < 3; i++) send_beat('1, 4'd8, 1'b0);
        send_beat(64'hFFFF_0000_FFFF_0000, 4'd8, 1'b1);
        for (int i = 0; i < 5; i++) send_beat(rand64(), 4'd8, 1'b0);
        send_beat('1, 4'd12, 1'b1);
        drain();

        // Extreme seeds, each written between messages while idle
        write_seed('0);
        send_message(4);
        send_message(1);
        drain();
        write_seed('1);
        send_message(9);
        send_message(0);
        drain();

        // Back-pressure: receiver holds off while beats keep flowing
        rx_hold = 1'b1;
        bursty = 1'b1;
        for (int m = 0; m < 6; m++) send_message($urandom_range(0, 5));
        bursty = 1'b0;
        drain();

        // Random part across several seeds
        while (beats_sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 9) == 0) begin
                drain();
                write_seed(($urandom_range(0, 3) == 0) ? P64_4 : rand64());
            end
            words = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                               : $urandom_range(13, 40);
            bursty = ($urandom_range(0, 4) == 0);
            send_message(words);
        end
        bursty = 1'b0;
        drain();

        $display("Covered %0d input beats and %0d hashes over several seeds,", beats_sent,
                 hashes_checked);
        $display("all tail sizes and receiver back-pressure.");
        if (sb.mismatches == 0 && sb.pending_hash.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
